### rtl/core/gap_pkg.sv
`default_nettype none
package gap_pkg;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [5:0]  cell_x;
    logic [5:0]  cell_y;
    logic        cell_passable;
    logic [5:0]  start_x;
    logic [5:0]  start_y;
    logic [5:0]  goal_x;
    logic [5:0]  goal_y;
    logic [11:0] read_index;
  } in_t;

  typedef struct packed {
    logic        path_found;
    logic [12:0] path_length;
    logic [5:0]  point_x;
    logic [5:0]  point_y;
  } out_t;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DISP, S_LOAD, S_READ, S_DONE, S_CLR, S_SEED_H, S_SEED_W,
    S_SCAN_CHK, S_SC_RD, S_SC_NODE, S_SC_CMP, S_SC_END, S_POP, S_RX_RD,
    S_RX_CHK, S_RX_W, S_PB_RD, S_PB_CHK
  } ctrl_state_t;

  typedef enum logic [4:0] {
    DP_NOP, DP_INIT_STEP, DP_CAPTURE, DP_LOAD, DP_READ_REQ, DP_OUT_LOAD,
    DP_CLR_STEP, DP_HSTART_SEED, DP_SEED, DP_SCAN_BEGIN, DP_SCAN_RD,
    DP_SCAN_NODE, DP_SCAN_CMP, DP_SCAN_END, DP_POP, DP_RX_RD, DP_HSTART_NB,
    DP_RX_WRITE, DP_RX_NEXT, DP_PB_RD, DP_PB_NEXT, DP_PB_END
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] item_op;
    logic       sweep_last;
    logic       ends_off;
    logic       heur_done;
    logic       list_empty;
    logic       scan_skip;
    logic       scan_last;
    logic       cur_is_goal;
    logic       nb_relax;
    logic       last_dir;
    logic       pb_parent;
    logic       out_free;
  } stat_t;

endpackage
`default_nettype wire

### rtl/core/gap_heur.sv
`default_nettype none
module gap_heur #(
  parameter int DX_W = 6,
  parameter int DY_W = 6
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   start,
  input  wire  [DX_W-1:0]                       dx,
  input  wire  [DY_W-1:0]                       dy,
  output logic                                  done,
  output logic [((DX_W > DY_W) ? DX_W : DY_W):0] root
);
  localparam int DW = (DX_W > DY_W) ? DX_W : DY_W;
  localparam int SW = 2 * DW + 1;
  localparam int RW = DW + 1;

  logic          busy_r;
  logic [SW-1:0] v_r, r_r, b_r;
  logic [SW:0]   trial;
  logic [SW-1:0] sq_sum;

  assign sq_sum = SW'(dx * dx) + SW'(dy * dy);
  assign trial  = {1'b0, r_r} + {1'b0, b_r};
  assign done   = busy_r && (b_r == '0);
  assign root   = RW'(r_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  // One result bit per cycle, highest bit pair first.
  always_ff @(posedge clk) begin
    if (start) begin
      v_r <= sq_sum;
      r_r <= '0;
      b_r <= SW'(1) << (SW - 1);
    end else if (busy_r && b_r != '0) begin
      if ({1'b0, v_r} >= trial) begin
        v_r <= SW'({1'b0, v_r} - trial);
        r_r <= (r_r >> 1) + b_r;
      end else begin
        r_r <= r_r >> 1;
      end
      b_r <= b_r >> 2;
    end
  end
endmodule
`default_nettype wire

### rtl/core/gap_dpath.sv
`default_nettype none
module gap_dpath #(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 64
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  gap_pkg::cmd_t       cmd,
  output gap_pkg::stat_t      st,
  input  gap_pkg::in_t        in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output gap_pkg::out_t       out_data
);
  localparam int XW    = $clog2(GRID_WIDTH);
  localparam int YW    = $clog2(GRID_HEIGHT);
  localparam int AW    = XW + YW;
  localparam int NODES = 1 << AW;
  localparam int CW    = AW + 1;
  localparam int DW    = (XW > YW) ? XW : YW;
  localparam int RW    = DW + 1;
  localparam int FW    = ((CW > RW) ? CW : RW) + 1;

  // Per-cell stores.
  logic          pass_mem [NODES];
  logic [2:0]    flag_mem [NODES];   // valid, has parent, in open list
  logic [CW-1:0] g_mem    [NODES];
  logic [FW-1:0] f_mem    [NODES];
  logic [AW-1:0] par_mem  [NODES];
  logic [AW-1:0] open_mem [NODES];
  logic [AW-1:0] path_mem [NODES];

  gap_pkg::in_t  item_r;
  gap_pkg::out_t out_r;
  logic          out_valid_r;
  logic [AW-1:0] sweep_r;
  logic [CW-1:0] len_r, phys_r, wr_j_r;
  logic [AW-1:0] rd_i_r, rm_idx_r, best_pos_r, best_cell_r, cell_r, pb_c_r, pb_n_r;
  logic          rm_valid_r, first_r;
  logic [1:0]    dir_r;
  logic [CW-1:0] best_g_r;
  logic [FW-1:0] best_f_r;
  logic [2:0]    best_flag_r;
  logic [AW-1:0] best_par_r;

  logic          pass_q;
  logic [2:0]    flag_q;
  logic [CW-1:0] g_q;
  logic [FW-1:0] f_q;
  logic [AW-1:0] par_q, open_q, path_q;

  logic [XW-1:0] sx, gx, cx, nb_x, hx, dx;
  logic [YW-1:0] sy, gy, cy, nb_y, hy, dy;
  logic [AW-1:0] s_addr, g_addr, nb_addr, nd_ra;
  logic          nb_ok, load_on, ends_off;
  logic [CW-1:0] t_cost;
  logic [RW-1:0] h_val;
  logic          h_done, h_start, nd_re;

  logic          nd_we;
  logic [AW-1:0] nd_wa;
  logic [2:0]    nd_wflag;
  logic [CW-1:0] nd_wg;
  logic [FW-1:0] nd_wf;
  logic [AW-1:0] nd_wpar;
  logic          ol_we;
  logic [AW-1:0] ol_wa, ol_wd;

  gap_pkg::dp_op_t op;
  assign op = cmd.op;

  assign sx = XW'(item_r.start_x);
  assign sy = YW'(item_r.start_y);
  assign gx = XW'(item_r.goal_x);
  assign gy = YW'(item_r.goal_y);
  assign s_addr = {sy, sx};
  assign g_addr = {gy, gx};
  assign cx = best_cell_r[XW-1:0];
  assign cy = best_cell_r[AW-1:XW];

  assign load_on  = (32'(item_r.cell_x) < 32'(GRID_WIDTH)) &&
                    (32'(item_r.cell_y) < 32'(GRID_HEIGHT));
  assign ends_off = (32'(item_r.start_x) >= 32'(GRID_WIDTH))  ||
                    (32'(item_r.start_y) >= 32'(GRID_HEIGHT)) ||
                    (32'(item_r.goal_x)  >= 32'(GRID_WIDTH))  ||
                    (32'(item_r.goal_y)  >= 32'(GRID_HEIGHT));

  always_comb begin
    nb_x  = cx;
    nb_y  = cy;
    nb_ok = 1'b0;
    case (dir_r)
      gap_pkg::DIR_LEFT: begin
        nb_ok = cx != '0;
        nb_x  = cx - 1'b1;
      end
      gap_pkg::DIR_RIGHT: begin
        nb_ok = cx != XW'(GRID_WIDTH - 1);
        nb_x  = cx + 1'b1;
      end
      gap_pkg::DIR_UP: begin
        nb_ok = cy != '0;
        nb_y  = cy - 1'b1;
      end
      default: begin
        nb_ok = cy != YW'(GRID_HEIGHT - 1);
        nb_y  = cy + 1'b1;
      end
    endcase
  end
  assign nb_addr = {nb_y, nb_x};
  assign t_cost  = best_g_r + CW'(1);

  // Heuristic unit, shared by the start cell and every relaxed neighbor.
  assign h_start = (op == gap_pkg::DP_HSTART_SEED) || (op == gap_pkg::DP_HSTART_NB);
  assign hx = (op == gap_pkg::DP_HSTART_SEED) ? sx : nb_x;
  assign hy = (op == gap_pkg::DP_HSTART_SEED) ? sy : nb_y;
  assign dx = (hx > gx) ? hx - gx : gx - hx;
  assign dy = (hy > gy) ? hy - gy : gy - hy;

  gap_heur #(.DX_W(XW), .DY_W(YW)) u_heur (
    .clk   (clk),
    .rst_n (rst_n),
    .start (h_start),
    .dx    (dx),
    .dy    (dy),
    .done  (h_done),
    .root  (h_val)
  );

  // Node store write and read port selection.
  always_comb begin
    nd_we    = 1'b0;
    nd_wa    = sweep_r;
    nd_wflag = '0;
    nd_wg    = '0;
    nd_wf    = '0;
    nd_wpar  = '0;
    case (op)
      gap_pkg::DP_INIT_STEP, gap_pkg::DP_CLR_STEP: begin
        nd_we = 1'b1;
      end
      gap_pkg::DP_SEED: begin
        nd_we    = 1'b1;
        nd_wa    = s_addr;
        nd_wflag = 3'b101;
        nd_wf    = FW'(h_val);
      end
      gap_pkg::DP_POP: begin
        nd_we    = 1'b1;
        nd_wa    = best_cell_r;
        nd_wflag = {best_flag_r[2:1], 1'b0};
        nd_wg    = best_g_r;
        nd_wf    = best_f_r;
        nd_wpar  = best_par_r;
      end
      gap_pkg::DP_RX_WRITE: begin
        nd_we    = 1'b1;
        nd_wa    = nb_addr;
        nd_wflag = 3'b111;
        nd_wg    = t_cost;
        nd_wf    = FW'(t_cost) + FW'(h_val);
        nd_wpar  = best_cell_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    nd_re = 1'b1;
    case (op)
      gap_pkg::DP_SCAN_NODE: nd_ra = open_q;
      gap_pkg::DP_RX_RD:     nd_ra = nb_addr;
      gap_pkg::DP_PB_RD:     nd_ra = pb_c_r;
      default: begin
        nd_re = 1'b0;
        nd_ra = pb_c_r;
      end
    endcase
  end

  always_comb begin
    ol_we = 1'b0;
    ol_wa = wr_j_r[AW-1:0];
    ol_wd = open_q;
    case (op)
      gap_pkg::DP_SEED: begin
        ol_we = 1'b1;
        ol_wa = '0;
        ol_wd = s_addr;
      end
      gap_pkg::DP_SCAN_NODE: begin
        ol_we = !st.scan_skip;
      end
      gap_pkg::DP_RX_WRITE: begin
        ol_we = !flag_q[0];
        ol_wa = phys_r[AW-1:0];
        ol_wd = nb_addr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (op == gap_pkg::DP_INIT_STEP) begin
      pass_mem[sweep_r] <= 1'b0;
    end else if (op == gap_pkg::DP_LOAD && load_on) begin
      pass_mem[{YW'(item_r.cell_y), XW'(item_r.cell_x)}] <= item_r.cell_passable;
    end
    if (op == gap_pkg::DP_RX_RD) begin
      pass_q <= pass_mem[nb_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (nd_we) begin
      flag_mem[nd_wa] <= nd_wflag;
      g_mem[nd_wa]    <= nd_wg;
      f_mem[nd_wa]    <= nd_wf;
      par_mem[nd_wa]  <= nd_wpar;
    end
    if (nd_re) begin
      flag_q <= flag_mem[nd_ra];
      g_q    <= g_mem[nd_ra];
      f_q    <= f_mem[nd_ra];
      par_q  <= par_mem[nd_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (ol_we) begin
      open_mem[ol_wa] <= ol_wd;
    end
    if (op == gap_pkg::DP_SCAN_RD) begin
      open_q <= open_mem[rd_i_r];
    end
  end

  // The path is stored goal first; reads count back from the end.
  always_ff @(posedge clk) begin
    if (op == gap_pkg::DP_PB_RD) begin
      path_mem[pb_n_r] <= pb_c_r;
    end
    if (op == gap_pkg::DP_READ_REQ) begin
      path_q <= path_mem[AW'(32'(len_r) - 32'd1 - 32'(item_r.read_index))];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= '0;
      len_r       <= '0;
      phys_r      <= '0;
      rm_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (op == gap_pkg::DP_OUT_LOAD) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (op)
        gap_pkg::DP_INIT_STEP, gap_pkg::DP_CLR_STEP: sweep_r <= sweep_r + 1'b1;
        gap_pkg::DP_CAPTURE: begin
          sweep_r <= '0;
          if (in_data.opcode == gap_pkg::OP_SEARCH) begin
            len_r      <= '0;
            phys_r     <= '0;
            rm_valid_r <= 1'b0;
          end
        end
        gap_pkg::DP_SEED:     phys_r <= CW'(1);
        gap_pkg::DP_SCAN_END: begin
          phys_r     <= wr_j_r;
          rm_valid_r <= 1'b0;
        end
        gap_pkg::DP_POP:      rm_valid_r <= 1'b1;
        gap_pkg::DP_RX_WRITE: begin
          if (!flag_q[0]) begin
            phys_r <= phys_r + 1'b1;
          end
        end
        gap_pkg::DP_PB_END:   len_r <= CW'(pb_n_r) + CW'(1);
        default: ;
      endcase
    end
  end

  // Working registers of the search.
  always_ff @(posedge clk) begin
    case (op)
      gap_pkg::DP_CAPTURE: item_r <= in_data;
      gap_pkg::DP_SCAN_BEGIN: begin
        rd_i_r  <= '0;
        wr_j_r  <= '0;
        first_r <= 1'b1;
      end
      gap_pkg::DP_SCAN_NODE: begin
        cell_r <= open_q;
        if (st.scan_skip) begin
          rd_i_r <= rd_i_r + 1'b1;
        end
      end
      gap_pkg::DP_SCAN_CMP: begin
        // Strict compare keeps the earliest entry on equal estimates.
        if (first_r || f_q < best_f_r) begin
          best_f_r    <= f_q;
          best_g_r    <= g_q;
          best_flag_r <= flag_q;
          best_par_r  <= par_q;
          best_pos_r  <= wr_j_r[AW-1:0];
          best_cell_r <= cell_r;
        end
        first_r <= 1'b0;
        rd_i_r  <= rd_i_r + 1'b1;
        wr_j_r  <= wr_j_r + 1'b1;
      end
      gap_pkg::DP_SCAN_END: begin
        pb_c_r <= best_cell_r;
        pb_n_r <= '0;
      end
      gap_pkg::DP_POP: begin
        rm_idx_r <= best_pos_r;
        dir_r    <= gap_pkg::DIR_LEFT;
      end
      gap_pkg::DP_RX_WRITE, gap_pkg::DP_RX_NEXT: dir_r <= dir_r + 1'b1;
      gap_pkg::DP_PB_NEXT: begin
        pb_c_r <= par_q;
        pb_n_r <= pb_n_r + 1'b1;
      end
      gap_pkg::DP_OUT_LOAD: begin
        out_r.path_found  <= len_r != '0;
        out_r.path_length <= 13'(len_r);
        if (item_r.opcode == gap_pkg::OP_READ &&
            32'(item_r.read_index) < 32'(len_r)) begin
          out_r.point_x <= 6'(path_q[XW-1:0]);
          out_r.point_y <= 6'(path_q[AW-1:XW]);
        end else begin
          out_r.point_x <= '0;
          out_r.point_y <= '0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    st.item_op     = item_r.opcode;
    st.sweep_last  = sweep_r == AW'(NODES - 1);
    st.ends_off    = ends_off;
    st.heur_done   = h_done;
    st.list_empty  = phys_r == CW'(rm_valid_r);
    st.scan_skip   = rm_valid_r && (rd_i_r == rm_idx_r);
    st.scan_last   = CW'(rd_i_r) == (phys_r - CW'(1));
    st.cur_is_goal = best_cell_r == g_addr;
    st.nb_relax    = nb_ok && pass_q && (!flag_q[2] || t_cost < g_q);
    st.last_dir    = dir_r == gap_pkg::DIR_DOWN;
    st.pb_parent   = flag_q[1];
    st.out_free    = !out_valid_r || !out_stall;
  end
endmodule
`default_nettype wire

### rtl/core/gap_ctrl.sv
`default_nettype none
module gap_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  gap_pkg::stat_t     st,
  output gap_pkg::cmd_t      cmd
);
  gap_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gap_pkg::S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gap_pkg::S_INIT:     if (st.sweep_last) state_nxt = gap_pkg::S_IDLE;
      gap_pkg::S_IDLE:     if (in_valid) state_nxt = gap_pkg::S_DISP;
      gap_pkg::S_DISP: begin
        unique case (st.item_op)
          gap_pkg::OP_LOAD:   state_nxt = gap_pkg::S_LOAD;
          gap_pkg::OP_SEARCH: state_nxt = gap_pkg::S_CLR;
          gap_pkg::OP_READ:   state_nxt = gap_pkg::S_READ;
          default:            state_nxt = gap_pkg::S_DONE;
        endcase
      end
      gap_pkg::S_LOAD:     state_nxt = gap_pkg::S_DONE;
      gap_pkg::S_READ:     state_nxt = gap_pkg::S_DONE;
      gap_pkg::S_DONE:     if (st.out_free) state_nxt = gap_pkg::S_IDLE;
      gap_pkg::S_CLR: begin
        if (st.sweep_last) begin
          state_nxt = st.ends_off ? gap_pkg::S_DONE : gap_pkg::S_SEED_H;
        end
      end
      gap_pkg::S_SEED_H:   state_nxt = gap_pkg::S_SEED_W;
      gap_pkg::S_SEED_W:   if (st.heur_done) state_nxt = gap_pkg::S_SCAN_CHK;
      gap_pkg::S_SCAN_CHK: begin
        state_nxt = st.list_empty ? gap_pkg::S_DONE : gap_pkg::S_SC_RD;
      end
      gap_pkg::S_SC_RD:    state_nxt = gap_pkg::S_SC_NODE;
      gap_pkg::S_SC_NODE: begin
        if (!st.scan_skip) begin
          state_nxt = gap_pkg::S_SC_CMP;
        end else begin
          state_nxt = st.scan_last ? gap_pkg::S_SC_END : gap_pkg::S_SC_RD;
        end
      end
      gap_pkg::S_SC_CMP: begin
        state_nxt = st.scan_last ? gap_pkg::S_SC_END : gap_pkg::S_SC_RD;
      end
      gap_pkg::S_SC_END: begin
        state_nxt = st.cur_is_goal ? gap_pkg::S_PB_RD : gap_pkg::S_POP;
      end
      gap_pkg::S_POP:      state_nxt = gap_pkg::S_RX_RD;
      gap_pkg::S_RX_RD:    state_nxt = gap_pkg::S_RX_CHK;
      gap_pkg::S_RX_CHK: begin
        if (st.nb_relax) begin
          state_nxt = gap_pkg::S_RX_W;
        end else begin
          state_nxt = st.last_dir ? gap_pkg::S_SCAN_CHK : gap_pkg::S_RX_RD;
        end
      end
      gap_pkg::S_RX_W: begin
        if (st.heur_done) begin
          state_nxt = st.last_dir ? gap_pkg::S_SCAN_CHK : gap_pkg::S_RX_RD;
        end
      end
      gap_pkg::S_PB_RD:    state_nxt = gap_pkg::S_PB_CHK;
      gap_pkg::S_PB_CHK: begin
        state_nxt = st.pb_parent ? gap_pkg::S_PB_RD : gap_pkg::S_DONE;
      end
      default:             state_nxt = gap_pkg::S_INIT;
    endcase
  end

  always_comb begin
    cmd.op   = gap_pkg::DP_NOP;
    in_stall = 1'b1;
    unique case (state_r)
      gap_pkg::S_INIT: cmd.op = gap_pkg::DP_INIT_STEP;
      gap_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) cmd.op = gap_pkg::DP_CAPTURE;
      end
      gap_pkg::S_LOAD:     cmd.op = gap_pkg::DP_LOAD;
      gap_pkg::S_READ:     cmd.op = gap_pkg::DP_READ_REQ;
      gap_pkg::S_DONE:     if (st.out_free) cmd.op = gap_pkg::DP_OUT_LOAD;
      gap_pkg::S_CLR:      cmd.op = gap_pkg::DP_CLR_STEP;
      gap_pkg::S_SEED_H:   cmd.op = gap_pkg::DP_HSTART_SEED;
      gap_pkg::S_SEED_W:   if (st.heur_done) cmd.op = gap_pkg::DP_SEED;
      gap_pkg::S_SCAN_CHK: if (!st.list_empty) cmd.op = gap_pkg::DP_SCAN_BEGIN;
      gap_pkg::S_SC_RD:    cmd.op = gap_pkg::DP_SCAN_RD;
      gap_pkg::S_SC_NODE:  cmd.op = gap_pkg::DP_SCAN_NODE;
      gap_pkg::S_SC_CMP:   cmd.op = gap_pkg::DP_SCAN_CMP;
      gap_pkg::S_SC_END:   cmd.op = gap_pkg::DP_SCAN_END;
      gap_pkg::S_POP:      cmd.op = gap_pkg::DP_POP;
      gap_pkg::S_RX_RD:    cmd.op = gap_pkg::DP_RX_RD;
      gap_pkg::S_RX_CHK: begin
        cmd.op = st.nb_relax ? gap_pkg::DP_HSTART_NB : gap_pkg::DP_RX_NEXT;
      end
      gap_pkg::S_RX_W:     if (st.heur_done) cmd.op = gap_pkg::DP_RX_WRITE;
      gap_pkg::S_PB_RD:    cmd.op = gap_pkg::DP_PB_RD;
      gap_pkg::S_PB_CHK: begin
        cmd.op = st.pb_parent ? gap_pkg::DP_PB_NEXT : gap_pkg::DP_PB_END;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

### rtl/core/grid_astar_path_search.sv
`default_nettype none
// Channel  Direction  Ports                              Item
// in       input      in_valid, in_stall, in_data        load, search or read request
// out      output     out_valid, out_stall, out_data     status and path point
//
// Every item gives one result. A search first clears the node store, one cell
// per cycle (width and height each rounded up to a power of two), then each
// selection scan reads every open-list entry; the selected cell's four neighbors
// are checked for relaxation or, once the goal is selected, the path is traced back.
// After reset the block sweeps the cell map for the same cell count before the
// first item is taken. A stalled result holds the next item until it is taken.
module grid_astar_path_search #(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 64
) (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_stall,
  input  gap_pkg::in_t   in_data,
  output logic           out_valid,
  input  wire            out_stall,
  output gap_pkg::out_t  out_data
);
  gap_pkg::cmd_t  cmd;
  gap_pkg::stat_t st;

  gap_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  gap_dpath #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );
endmodule
`default_nettype wire

### dv/tb.sv
module tb;

  localparam int SIDE = 64;
  localparam int NCELL = SIDE * SIDE;
  localparam int CYCLE_LIMIT = 20000000;
  localparam int IN_W = $bits(gap_pkg::in_t);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  gap_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  gap_pkg::out_t out_data;

  grid_astar_path_search u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the search state.
  bit walkable [NCELL];
  bit cost_known [NCELL];
  bit linked [NCELL];
  bit queued [NCELL];
  int g_cost [NCELL];
  int f_cost [NCELL];
  int came_from [NCELL];
  int frontier [NCELL];
  int route [NCELL];
  int frontier_len;
  int route_len;

  gap_pkg::in_t  pending_items [$];
  bit            pending_pause [$];
  gap_pkg::out_t status_expected [$];

  int mismatches = 0;
  int accepted = 0;
  int cycles = 0;
  int gap_left = 0;
  int hold_cycles = 0;
  int stall_pct = 0;
  int stall_phase = 0;
  bit long_hold_done = 1'b0;
  int bx, by;

  function automatic int floor_sqrt(int v);
    int r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  function automatic int dist_est(int x, int y, int gx, int gy);
    int dx, dy;
    dx = (x > gx) ? x - gx : gx - x;
    dy = (y > gy) ? y - gy : gy - y;
    return floor_sqrt(dx * dx + dy * dy);
  endfunction

  function automatic void find_route(int sx, int sy, int gx, int gy);
    int s, g, best, cur, cx, cy, nx, ny, nb, t, n, c;
    for (int i = 0; i < NCELL; i++) begin
      cost_known[i] = 0;
      linked[i] = 0;
      queued[i] = 0;
    end
    frontier_len = 0;
    route_len = 0;
    s = sy * SIDE + sx;
    g = gy * SIDE + gx;
    g_cost[s] = 0;
    f_cost[s] = dist_est(sx, sy, gx, gy);
    cost_known[s] = 1;
    frontier[0] = s;
    queued[s] = 1;
    frontier_len = 1;
    while (frontier_len > 0) begin
      best = 0;
      for (int i = 1; i < frontier_len; i++)
        if (f_cost[frontier[i]] < f_cost[frontier[best]]) best = i;
      cur = frontier[best];
      if (cur == g) begin
        n = 0;
        c = g;
        while (n < NCELL) begin
          route[n] = c;
          n++;
          if (!linked[c]) break;
          c = came_from[c];
        end
        for (int a = 0; a < n / 2; a++) begin
          t = route[a];
          route[a] = route[n - 1 - a];
          route[n - 1 - a] = t;
        end
        route_len = n;
        return;
      end
      for (int i = best; i < frontier_len - 1; i++) frontier[i] = frontier[i + 1];
      frontier_len--;
      queued[cur] = 0;
      cx = cur % SIDE;
      cy = cur / SIDE;
      for (int d = 0; d < 4; d++) begin
        nx = cx + ((d == gap_pkg::DIR_LEFT) ? -1 : (d == gap_pkg::DIR_RIGHT) ? 1 : 0);
        ny = cy + ((d == gap_pkg::DIR_UP) ? -1 : (d == gap_pkg::DIR_DOWN) ? 1 : 0);
        if (nx < 0 || ny < 0 || nx >= SIDE || ny >= SIDE) continue;
        nb = ny * SIDE + nx;
        if (!walkable[nb]) continue;
        t = g_cost[cur] + 1;
        if (!cost_known[nb] || t < g_cost[nb]) begin
          came_from[nb] = cur;
          linked[nb] = 1;
          g_cost[nb] = t;
          cost_known[nb] = 1;
          f_cost[nb] = t + dist_est(nx, ny, gx, gy);
          if (!queued[nb] && frontier_len < NCELL) begin
            frontier[frontier_len] = nb;
            frontier_len++;
            queued[nb] = 1;
          end
        end
      end
    end
  endfunction

  function automatic gap_pkg::out_t predict_status(gap_pkg::in_t it);
    gap_pkg::out_t r;
    r = '0;
    case (it.opcode)
      gap_pkg::OP_LOAD: walkable[int'(it.cell_y) * SIDE + int'(it.cell_x)] = it.cell_passable;
      gap_pkg::OP_SEARCH: find_route(int'(it.start_x), int'(it.start_y),
                                     int'(it.goal_x), int'(it.goal_y));
      gap_pkg::OP_READ: begin
        if (int'(it.read_index) < route_len) begin
          r.point_x = 6'(route[it.read_index] % SIDE);
          r.point_y = 6'(route[it.read_index] / SIDE);
        end
      end
      default: ;
    endcase
    r.path_found = (route_len > 0);
    r.path_length = 13'(route_len);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic push_item(gap_pkg::in_t it, bit pause);
    pending_items.push_back(it);
    pending_pause.push_back(pause);
  endtask

  function automatic gap_pkg::in_t blank_item(logic [1:0] op);
    gap_pkg::in_t it;
    it = gap_pkg::in_t'(IN_W'({$urandom, $urandom}));
    it.opcode = op;
    return it;
  endfunction

  task automatic add_load(int x, int y, bit p);
    gap_pkg::in_t it;
    it = blank_item(gap_pkg::OP_LOAD);
    it.cell_x = 6'(x); it.cell_y = 6'(y); it.cell_passable = p;
    push_item(it, 1'b0);
  endtask

  task automatic add_search(int sx, int sy, int gx, int gy);
    gap_pkg::in_t it;
    it = blank_item(gap_pkg::OP_SEARCH);
    it.start_x = 6'(sx); it.start_y = 6'(sy); it.goal_x = 6'(gx); it.goal_y = 6'(gy);
    push_item(it, 1'b0);
  endtask

  task automatic add_read(int k);
    gap_pkg::in_t it;
    it = blank_item(gap_pkg::OP_READ);
    it.read_index = 12'(k);
    push_item(it, 1'b0);
  endtask

  // Random items stay mostly inside a small 8x8 window so searches stay short.
  task automatic add_random_item(bit pause);
    gap_pkg::in_t it;
    int r;
    r = $urandom_range(0, 99);
    it = blank_item(gap_pkg::OP_LOAD);
    if (r < 55) begin
      it.cell_x = 6'(bx + $urandom_range(0, 7));
      it.cell_y = 6'(by + $urandom_range(0, 7));
      it.cell_passable = ($urandom_range(0, 3) != 0);
    end else if (r < 65) begin
      it.opcode = gap_pkg::OP_SEARCH;
      it.start_x = 6'(bx + $urandom_range(0, 7));
      it.start_y = 6'(by + $urandom_range(0, 7));
      it.goal_x = 6'(bx + $urandom_range(0, 7));
      it.goal_y = 6'(by + $urandom_range(0, 7));
    end else if (r < 88) begin
      it.opcode = gap_pkg::OP_READ;
      it.read_index = 12'($urandom_range(0, 20));
    end else if (r < 93) begin
      it.cell_passable = 1'b0;
    end else if (r < 96) begin
      it.opcode = gap_pkg::OP_SEARCH;
    end else if (r < 98) begin
      it.opcode = gap_pkg::OP_READ;
    end else begin
      it.opcode = gap_pkg::OP_NONE;
    end
    push_item(it, pause);
  endtask

  initial begin
    int bases [3];
    bases = '{0, 56, 24};
    add_load(0, 0, 1); add_load(1, 0, 1); add_load(0, 1, 1); add_load(1, 1, 1);
    add_load(63, 63, 1); add_load(63, 62, 1); add_load(62, 63, 1);
    add_search(0, 0, 1, 1);
    add_read(0); add_read(1); add_read(2); add_read(3); add_read(4095);
    add_search(62, 63, 63, 62);
    add_read(1);
    add_load(63, 63, 0);
    add_search(63, 62, 62, 63);
    add_search(5, 5, 5, 5);
    add_read(0);
    add_search(0, 0, 63, 63);
    add_read(0);
    add_search(1, 1, 0, 0);
    push_item(blank_item(gap_pkg::OP_NONE), 1'b0);
    add_read(2);
    for (int i = 0; i < 730; i++) begin
      if (i % 60 == 0) begin
        bx = bases[$urandom_range(0, 2)];
        by = bases[$urandom_range(0, 2)];
      end
      add_random_item(i == 400);
    end
  end

  // Driver: offers the next item when the current one is taken or none is up.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        status_expected.push_back(predict_status(in_data));
        accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0 &&
                     !(pending_pause[0] && status_expected.size() > 0)) begin
          in_data <= pending_items.pop_front();
          void'(pending_pause.pop_front());
          in_valid <= 1'b1;
          gap_left = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall, with one long hold-off while the sender keeps offering.
  always @(posedge clk) begin
    if (stall_phase == 0) begin
      stall_phase = $urandom_range(20, 80);
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 20;
        default: stall_pct = 60;
      endcase
    end
    stall_phase--;
    if (!long_hold_done && accepted >= 40) begin
      long_hold_done = 1'b1;
      hold_cycles = 400;
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Monitor.
  always @(posedge clk) begin
    gap_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (status_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        want = status_expected.pop_front();
        if (out_data.path_found !== want.path_found ||
            out_data.path_length !== want.path_length ||
            out_data.point_x !== want.point_x ||
            out_data.point_y !== want.point_y) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p actual %p", want, out_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_items.size() == 0 && !in_valid && status_expected.size() == 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && status_expected.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/gap_pkg.sv
rtl/core/gap_heur.sv
rtl/core/gap_dpath.sv
rtl/core/gap_ctrl.sv
rtl/core/grid_astar_path_search.sv
dv/tb.sv
